// ===== hw/rtl/lpd3_pkg.sv =====
// shared types, register indexes and constants of the line / point detector
package lpd3_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// reset values of the configuration registers
	localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
	localparam logic [7:0]  MASK_GAIN_RST    = 8'd1;

	// round(s / 9) as ((s + 4) * RECIP_9) >> RECIP_SHIFT, exact for s + 4 < 3640
	localparam logic [11:0] RECIP_9     = 12'd3641;
	localparam int          RECIP_SHIFT = 15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_MODE    = 3'd0,
		REG_LINE_DIR     = 3'd1,
		REG_MASK_GAIN    = 3'd2,
		REG_FRAME_WIDTH  = 3'd3,
		REG_FRAME_HEIGHT = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIR_VERT  = 2'd0,
		DIR_POS45 = 2'd1,
		DIR_NEG45 = 2'd2,
		DIR_HORIZ = 2'd3
	} line_dir_t;

	// one column of the 3x3 window
	typedef struct packed {
		logic [7:0] top;
		logic [7:0] mid;
		logic [7:0] bot;
	} col3_t;

	// one result item
	typedef struct packed {
		logic [7:0] pix;
		logic       fe;
	} res_t;

endpackage

// ===== hw/rtl/line_point_detect_3x3_unit.sv =====
// top level: 3x3 box smoothing followed by a 3x3 line or point mask
//
// Input channel in_valid / in_ready carries req_type and pixel_in in raster
// order; flush items (req_type 1) drain the tail of a frame. A frame takes
// W*H + 2*W + 2 items, the result for pixel k is formed by item k + 2*W + 2,
// so the first 2*W + 2 items of a frame give no result.
// Output channel out_valid / out_ready carries edge_pixel and frame_end.
// Each item passes stages 1 to 6, its result then the output queue. One item is
// accepted per cycle while in_ready is high: two row-buffer memories
// (raw pixels and smoothed pixels, one word of two rows per column, one read
// and one write per cycle) and a six-stage pipeline carry the work.
// A two-entry output queue lets the block keep accepting while a result waits;
// when the queue is full and out_ready is low the whole pipeline holds and
// in_ready drops. The configuration channel cfg_valid / cfg_ready writes one
// register per cycle and is always ready; sizes take effect at frame start.
// Reset (arst_n low) clears the pipeline, the queue, the frame counters and
// the registers to their reset values. The row buffers need no clearing:
// every stale entry is replaced by border mirroring before use.
module line_point_detect_3x3_unit #(
	parameter int MAX_WIDTH  = lpd3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lpd3_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             req_type,
	input  logic [7:0]                       pixel_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       edge_pixel,
	output logic                             frame_end,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lpd3_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lpd3_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lpd3_pkg::*;

	localparam int CI = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 3);

	function automatic logic [CW-1:0] clamp_w(input logic [11:0] v);
		logic [31:0] x;
		x = 32'(v);
		if (x < 32'd3)
			return CW'(3);
		else if (x > 32'(MAX_WIDTH))
			return CW'(MAX_WIDTH);
		else
			return CW'(x);
	endfunction

	function automatic logic [RW-1:0] clamp_h(input logic [11:0] v);
		logic [31:0] x;
		x = 32'(v);
		if (x < 32'd3)
			return RW'(3);
		else if (x > 32'(MAX_HEIGHT))
			return RW'(MAX_HEIGHT);
		else
			return RW'(x);
	endfunction

	// configuration registers
	logic        line_mode_q;
	logic [1:0]  line_dir_q;
	logic [7:0]  gain_q;
	logic [11:0] fw_q;
	logic [11:0] fh_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_mode_q <= 1'b1;
			line_dir_q  <= DIR_VERT;
			gain_q      <= MASK_GAIN_RST;
			fw_q        <= FRAME_WIDTH_RST;
			fh_q        <= FRAME_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LINE_MODE:    line_mode_q <= cfg_data[0];
				REG_LINE_DIR:     line_dir_q  <= cfg_data[1:0];
				REG_MASK_GAIN:    gain_q      <= cfg_data[7:0];
				REG_FRAME_WIDTH:  fw_q        <= cfg_data[11:0];
				REG_FRAME_HEIGHT: fh_q        <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// pipeline enable and output queue
	logic [1:0] cnt_q;
	res_t       ent0_q, ent1_q;
	logic       en, push, pop;
	res_t       res_new;

	assign en        = (cnt_q != 2'd2) || out_ready;
	assign in_ready  = en;
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign edge_pixel = ent0_q.pix;
	assign frame_end  = ent0_q.fe;

	// ---------------- input stage: frame position ----------------
	logic [CI-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] act_w_q, w_cur;
	logic [RW-1:0] act_h_q, h_cur;
	logic          acc_in, fst_a, last_a, wrap_a, mpos_a, outv_a;

	assign acc_in = in_valid && en;
	assign fst_a  = (col_q == '0) && (row_q == '0);
	assign w_cur  = fst_a ? clamp_w(fw_q) : act_w_q;
	assign h_cur  = fst_a ? clamp_h(fh_q) : act_h_q;
	assign last_a = (row_q == h_cur + RW'(2)) && (col_q == CI'(1));
	assign wrap_a = (CW'(col_q) + CW'(1)) == w_cur;
	// smoothed position n - W - 1 exists
	assign mpos_a = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
	// result position n - 2W - 2 exists
	assign outv_a = (row_q >= RW'(3)) || ((row_q == RW'(2)) && (col_q >= CI'(2)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			act_w_q <= clamp_w(FRAME_WIDTH_RST);
			act_h_q <= clamp_h(FRAME_HEIGHT_RST);
		end else if (acc_in) begin
			if (fst_a) begin
				act_w_q <= w_cur;
				act_h_q <= h_cur;
			end
			if (last_a) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap_a) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CI'(1);
			end
		end
	end

	// ---------------- stage 1: raw column ----------------
	logic [15:0]   rmem [0:MAX_WIDTH-1];
	logic [15:0]   rrd_s1;
	logic          v_s1, topm_s1, botm_s1, cf_s1, cl_s1, mpos_s1, outv_s1, last_s1, fst_s1;
	logic [CI-1:0] col_s1;
	logic [7:0]    pix_s1;

	always_ff @(posedge clk) begin
		if (en)
			rrd_s1 <= rmem[col_q];
	end

	always_ff @(posedge clk) begin
		if (en && v_s1)
			rmem[col_s1] <= {rrd_s1[7:0], pix_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= acc_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1  <= col_q;
			pix_s1  <= (req_type || (row_q >= h_cur)) ? 8'd0 : pixel_in;
			topm_s1 <= (row_q == RW'(1));
			botm_s1 <= (row_q == h_cur);
			cf_s1   <= (col_q == CI'(1));
			cl_s1   <= (col_q == '0);
			mpos_s1 <= mpos_a;
			outv_s1 <= outv_a;
			last_s1 <= last_a;
			fst_s1  <= fst_a;
		end
	end

	logic [7:0] rtop, rbot;
	logic [9:0] colsum;

	// vertical mirror: row -1 reads row 1, row H reads row H-2
	assign rtop   = topm_s1 ? pix_s1 : rrd_s1[15:8];
	assign rbot   = botm_s1 ? rrd_s1[15:8] : pix_s1;
	assign colsum = 10'(rtop) + 10'(rrd_s1[7:0]) + 10'(rbot);

	// ---------------- stage 2: box window of column sums ----------------
	logic [9:0] win_l_s2, win_m_s2, win_r_s2;
	logic       v_s2, cf_s2, cl_s2, mpos_s2, outv_s2, last_s2, fst_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s1) begin
				win_l_s2 <= win_m_s2;
				win_m_s2 <= win_r_s2;
				win_r_s2 <= colsum;
			end
			cf_s2   <= cf_s1;
			cl_s2   <= cl_s1;
			mpos_s2 <= mpos_s1;
			outv_s2 <= outv_s1;
			last_s2 <= last_s1;
			fst_s2  <= fst_s1;
		end
	end

	logic [11:0] box_sum;
	logic [9:0]  bl, br;

	assign bl      = cf_s2 ? win_r_s2 : win_l_s2;
	assign br      = cl_s2 ? win_l_s2 : win_r_s2;
	assign box_sum = 12'(bl) + 12'(win_m_s2) + 12'(br);

	// ---------------- stage 3: rounded mean, smoothed position ----------------
	logic [11:0]   sum_s3;
	logic          v_s3, mpos_s3, outv_s3, last_s3, fst_s3;
	logic [CI-1:0] col2_q;
	logic [RW-1:0] row2_q;
	logic [CW-1:0] w2_q;
	logic [RW-1:0] h2_q;
	logic [23:0]   mean_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= box_sum + 12'd4;
			mpos_s3 <= mpos_s2;
			outv_s3 <= outv_s2;
			last_s3 <= last_s2;
			fst_s3  <= fst_s2;
		end
	end

	assign mean_prod = 24'(sum_s3) * 24'(RECIP_9);

	// position of the smoothed stream, restarted by each frame's first item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col2_q <= '0;
			row2_q <= '0;
			w2_q   <= clamp_w(FRAME_WIDTH_RST);
			h2_q   <= clamp_h(FRAME_HEIGHT_RST);
		end else if (en && v_s3) begin
			if (fst_s3) begin
				col2_q <= '0;
				row2_q <= '0;
				w2_q   <= act_w_q;
				h2_q   <= act_h_q;
			end else if (mpos_s3) begin
				if ((CW'(col2_q) + CW'(1)) == w2_q) begin
					col2_q <= '0;
					row2_q <= row2_q + RW'(1);
				end else begin
					col2_q <= col2_q + CI'(1);
				end
			end
		end
	end

	// ---------------- stage 4: smoothed column ----------------
	logic [15:0]   smem [0:MAX_WIDTH-1];
	logic [15:0]   srd_s4;
	logic [7:0]    smooth_s4;
	logic          v_s4, mpos_s4, outv_s4, last_s4, topm_s4, botm_s4, cf_s4, cl_s4;
	logic [CI-1:0] col_s4;

	always_ff @(posedge clk) begin
		if (en)
			srd_s4 <= smem[col2_q];
	end

	always_ff @(posedge clk) begin
		if (en && v_s4 && mpos_s4)
			smem[col_s4] <= {srd_s4[7:0], smooth_s4};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smooth_s4 <= mean_prod[RECIP_SHIFT +: 8];
			mpos_s4   <= mpos_s3;
			outv_s4   <= outv_s3;
			last_s4   <= last_s3;
			col_s4    <= col2_q;
			topm_s4   <= (row2_q == RW'(1));
			botm_s4   <= (row2_q == h2_q);
			cf_s4     <= (col2_q == CI'(1));
			cl_s4     <= (col2_q == '0);
		end
	end

	col3_t scol;

	assign scol.top = topm_s4 ? smooth_s4 : srd_s4[15:8];
	assign scol.mid = srd_s4[7:0];
	assign scol.bot = botm_s4 ? srd_s4[15:8] : smooth_s4;

	// ---------------- stage 5: mask window ----------------
	col3_t mw_l_s5, mw_m_s5, mw_r_s5;
	logic  v_s5, outv_s5, last_s5, cf_s5, cl_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s4 && mpos_s4) begin
				mw_l_s5 <= mw_m_s5;
				mw_m_s5 <= mw_r_s5;
				mw_r_s5 <= scol;
			end
			outv_s5 <= outv_s4;
			last_s5 <= last_s4;
			cf_s5   <= cf_s4;
			cl_s5   <= cl_s4;
		end
	end

	col3_t       ml, mr;
	logic [7:0]  p [0:8];
	logic [11:0] all9, line3;
	logic signed [12:0] acc_units;

	assign ml = cf_s5 ? mw_r_s5 : mw_l_s5;
	assign mr = cl_s5 ? mw_l_s5 : mw_r_s5;

	assign p[0] = ml.top;  assign p[1] = mw_m_s5.top;  assign p[2] = mr.top;
	assign p[3] = ml.mid;  assign p[4] = mw_m_s5.mid;  assign p[5] = mr.mid;
	assign p[6] = ml.bot;  assign p[7] = mw_m_s5.bot;  assign p[8] = mr.bot;

	assign all9 = 12'(p[0]) + 12'(p[1]) + 12'(p[2]) + 12'(p[3]) + 12'(p[4])
		+ 12'(p[5]) + 12'(p[6]) + 12'(p[7]) + 12'(p[8]);

	always_comb begin
		case (line_dir_q)
			DIR_VERT:  line3 = 12'(p[1]) + 12'(p[4]) + 12'(p[7]);
			DIR_POS45: line3 = 12'(p[2]) + 12'(p[4]) + 12'(p[6]);
			DIR_NEG45: line3 = 12'(p[0]) + 12'(p[4]) + 12'(p[8]);
			DIR_HORIZ: line3 = 12'(p[3]) + 12'(p[4]) + 12'(p[5]);
			default:   line3 = 12'(p[1]) + 12'(p[4]) + 12'(p[7]);
		endcase
	end

	// 2 on the line, -1 off it: 3*line - all; point: all - 9*centre
	always_comb begin
		if (line_mode_q)
			acc_units = 13'sd3 * $signed({1'b0, line3}) - $signed({1'b0, all9});
		else
			acc_units = $signed({1'b0, all9}) - 13'sd9 * $signed({5'b0, p[4]});
	end

	// ---------------- stage 6: gain and saturation ----------------
	logic signed [12:0] acc_s6;
	logic               v_s6, outv_s6, last_s6;
	logic signed [21:0] gprod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s6  <= acc_units;
			outv_s6 <= outv_s5;
			last_s6 <= last_s5;
		end
	end

	assign gprod = 22'(acc_s6) * $signed({14'b0, gain_q});

	always_comb begin
		res_new.fe = last_s6;
		if (gprod < 22'sd0)
			res_new.pix = 8'd0;
		else if (gprod > 22'sd255)
			res_new.pix = 8'd255;
		else
			res_new.pix = gprod[7:0];
	end

	assign push = en && v_s6 && outv_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else if (push && !pop)
			cnt_q <= cnt_q + 2'd1;
		else if (pop && !push)
			cnt_q <= cnt_q - 2'd1;
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (cnt_q == 2'd1) begin
				ent0_q <= res_new;
			end else begin
				ent0_q <= ent1_q;
				ent1_q <= res_new;
			end
		end else if (pop) begin
			ent0_q <= ent1_q;
		end else if (push) begin
			if (cnt_q == 2'd0)
				ent0_q <= res_new;
			else
				ent1_q <= res_new;
		end
	end

endmodule

// ===== hw/rtl/lpd3_checker.sv =====
// port-level checks of the line / point detector and their binding
module lpd3_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] edge_pixel,
	input logic       frame_end,
	input logic       cfg_ready
);

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(edge_pixel) && $stable(frame_end))
		else $error("result changed while stalled");

	// input stalls only behind a full queue that the receiver does not drain
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");

	// with no result pending the block always takes an item
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output empty");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready && cfg_ready)
		else $error("not ready while receiver takes results");

endmodule

bind line_point_detect_3x3_unit lpd3_checker u_lpd3_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.edge_pixel (edge_pixel),
	.frame_end  (frame_end),
	.cfg_ready  (cfg_ready)
);
